// ===== design/path_following_speed_limiter_assert.svh =====
// ----------------------------------------------------------------------------
// Path following speed limiter assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef PATH_FOLLOWING_SPEED_LIMITER_ASSERT_SVH
`define PATH_FOLLOWING_SPEED_LIMITER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPL_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/spl_pkg.sv =====
// ----------------------------------------------------------------------------
// Speed limiter package
// Widths, latencies and fixed-point constants of the speed limiter.
// ----------------------------------------------------------------------------
package spl_pkg;

   localparam int SPEED_W    = 16;
   localparam int DIV_STEPS  = 25;
   localparam int SQRT_STEPS = 13;
   localparam int LOG_STEPS  = 16;
   localparam int CURV_LAT   = DIV_STEPS + SQRT_STEPS;
   localparam int DEV_LAT    = LOG_STEPS + 2;
   localparam int DEV_PAD    = CURV_LAT - DEV_LAT;

   localparam logic [DIV_STEPS-1:0] K1_CURV  = 25'd26843546;
   localparam logic [19:0]          C0_LOG   = 20'd568726;
   localparam longint               A0_BASE  = 312388;
   localparam logic signed [39:0]   A0_TERM  = 40'(A0_BASE * 65536);
   localparam logic signed [17:0]   B0_SLOPE = 18'sd65609;

endpackage

// ===== design/spl_if.sv =====
// ----------------------------------------------------------------------------
// Speed limiter channel interfaces
// Request, response and register write channels with valid and ready.
// ----------------------------------------------------------------------------
interface spl_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] requested_speed;
   logic signed [15:0] curv_now;
   logic signed [15:0] curv_ahead;
   logic signed [15:0] lat_offset;

   modport source (output valid, output requested_speed, output curv_now,
                   output curv_ahead, output lat_offset, input ready);
   modport sink   (input valid, input requested_speed, input curv_now,
                   input curv_ahead, input lat_offset, output ready);
endinterface

interface spl_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] limited_speed;

   modport source (output valid, output limited_speed, input ready);
   modport sink   (input valid, input limited_speed, output ready);
endinterface

interface spl_csr_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] minimum_speed;

   modport source (output valid, output minimum_speed, input ready);
   modport sink   (input valid, input minimum_speed, output ready);
endinterface

// ===== design/spl_delay.sv =====
// ----------------------------------------------------------------------------
// Speed limiter delay line
// Shift register that moves a word one stage per enabled cycle.
// ----------------------------------------------------------------------------
module spl_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d_i,
   output logic [WIDTH-1:0] q_o
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= d_i;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign q_o = tap_ff[DEPTH-1];

endmodule

// ===== design/spl_curv_ceiling.sv =====
// ----------------------------------------------------------------------------
// Speed limiter curvature ceiling
// Pipelined restoring divide of the gain by the curvature change, one
// quotient bit per stage, then a pipelined square root, one bit per stage.
// ----------------------------------------------------------------------------
module spl_curv_ceiling import spl_pkg::*; (
   input  logic                  clock,
   input  logic                  en,
   input  logic [15:0]           d_i,
   output logic [SQRT_STEPS-1:0] lim_o
);

   logic [15:0]             dd_ff  [DIV_STEPS];
   logic [15:0]             rem_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0]    q_ff   [DIV_STEPS];
   logic [2*SQRT_STEPS-1:0] x_ff   [SQRT_STEPS];
   logic [SQRT_STEPS+1:0]   sr_ff  [SQRT_STEPS];
   logic [SQRT_STEPS-1:0]   rt_ff  [SQRT_STEPS];

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      logic [15:0]          d_prev;
      logic [15:0]          rem_prev;
      logic [DIV_STEPS-1:0] q_prev;
      logic [16:0]          r;
      logic                 ge;

      if (i == 0) begin : g_first
         assign d_prev   = d_i;
         assign rem_prev = '0;
         assign q_prev   = '0;
      end else begin : g_next
         assign d_prev   = dd_ff[i-1];
         assign rem_prev = rem_ff[i-1];
         assign q_prev   = q_ff[i-1];
      end

      assign r  = {rem_prev, K1_CURV[DIV_STEPS-1-i]};
      assign ge = r >= {1'b0, d_prev};

      always_ff @(posedge clock) begin
         if (en) begin
            dd_ff[i]  <= d_prev;
            rem_ff[i] <= ge ? 16'(r - {1'b0, d_prev}) : r[15:0];
            q_ff[i]   <= {q_prev[DIV_STEPS-2:0], ge};
         end
      end
   end

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      logic [2*SQRT_STEPS-1:0] x_prev;
      logic [SQRT_STEPS+1:0]   rem_prev;
      logic [SQRT_STEPS-1:0]   root_prev;
      logic [SQRT_STEPS+3:0]   nr;
      logic [SQRT_STEPS+3:0]   trial;
      logic                    ge;

      if (j == 0) begin : g_first
         assign x_prev    = {1'b0, q_ff[DIV_STEPS-1]};
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign x_prev    = x_ff[j-1];
         assign rem_prev  = sr_ff[j-1];
         assign root_prev = rt_ff[j-1];
      end

      assign nr    = {rem_prev, x_prev[2*SQRT_STEPS-1-2*j -: 2]};
      assign trial = {2'b00, root_prev, 2'b01};
      assign ge    = nr >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[j]  <= x_prev;
            sr_ff[j] <= ge ? (SQRT_STEPS+2)'(nr - trial) : nr[SQRT_STEPS+1:0];
            rt_ff[j] <= {root_prev[SQRT_STEPS-2:0], ge};
         end
      end
   end

   assign lim_o = rt_ff[SQRT_STEPS-1];

endmodule

// ===== design/spl_dev_ceiling.sv =====
// ----------------------------------------------------------------------------
// Speed limiter deviation ceiling
// Pipelined base-2 logarithm by repeated squaring, one fraction bit per
// stage, then the affine map to a speed ceiling in Q8.8.
// ----------------------------------------------------------------------------
module spl_dev_ceiling import spl_pkg::*; (
   input  logic                      clock,
   input  logic                      en,
   input  logic [15:0]               a_i,
   output logic signed [SPEED_W-1:0] lim_o
);

   logic [30:0]          m_ff [LOG_STEPS+1];
   logic [3:0]           e_ff [LOG_STEPS+1];
   logic [LOG_STEPS-1:0] f_ff [LOG_STEPS+1];
   logic signed [39:0]   acc_ff;
   logic [3:0]           e_in;
   logic [19:0]          lg;
   logic signed [20:0]   t;

   always_comb begin
      e_in = '0;
      for (int k = 0; k < 16; k++) begin
         if (a_i[k]) begin
            e_in = 4'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff[0] <= {15'b0, a_i} << (5'd30 - {1'b0, e_in});
         e_ff[0] <= e_in;
         f_ff[0] <= '0;
      end
   end

   for (genvar k = 1; k <= LOG_STEPS; k++) begin : g_sq
      logic [61:0] p;
      logic [31:0] m2;

      assign p  = {31'b0, m_ff[k-1]} * {31'b0, m_ff[k-1]};
      assign m2 = p[61:30];

      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[k] <= m2[31] ? m2[31:1] : m2[30:0];
            e_ff[k] <= e_ff[k-1];
            f_ff[k] <= {f_ff[k-1][LOG_STEPS-2:0], m2[31]};
         end
      end
   end

   assign lg = {e_ff[LOG_STEPS], f_ff[LOG_STEPS]};
   assign t  = $signed({1'b0, C0_LOG}) - $signed({1'b0, lg});

   always_ff @(posedge clock) begin
      if (en) begin
         acc_ff <= A0_TERM + 40'(B0_SLOPE * t);
      end
   end

   assign lim_o = acc_ff[39:24];

endmodule

// ===== design/path_following_speed_limiter.sv =====
// ----------------------------------------------------------------------------
// Path following speed limiter
// Limits a requested speed by a curvature ceiling and a deviation ceiling, each
// used only when its input is nonzero, then raises it to the programmed minimum speed.
// ----------------------------------------------------------------------------
//   Channel  Direction  Contents
//   req      in         requested speed, curvatures, lateral deviation
//   rsp      out        limited speed
//   csr      in         minimum speed register
//
// One item is taken per cycle while the response is not stalled; a result passes
// through the input register, the 25 divide stages, the 13 square root stages
// and the output register.
// A stalled response freezes the whole pipeline; nothing is dropped.
// Reset clears the valid bits and sets the minimum speed to zero.
// ----------------------------------------------------------------------------
module path_following_speed_limiter import spl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   spl_req_if.sink    req,
   spl_rsp_if.source  rsp,
   spl_csr_if.sink    csr
);

   logic                      adv;
   logic signed [SPEED_W-1:0] min_ff;
   logic                      vld_ff [CURV_LAT+1];
   logic signed [SPEED_W-1:0] req_ff;
   logic [15:0]               d_ff;
   logic [15:0]               a_ff;
   logic                      rsp_vld_ff;
   logic signed [SPEED_W-1:0] rsp_ff;
   logic signed [16:0]        dk;
   logic signed [16:0]        yk;
   logic [15:0]               dk_abs;
   logic [15:0]               yk_abs;
   logic [SQRT_STEPS-1:0]     lim1;
   logic signed [SPEED_W-1:0] lim2_raw;
   logic signed [SPEED_W-1:0] lim2;
   logic [SPEED_W+1:0]        side;
   logic signed [SPEED_W-1:0] req_d;
   logic                      curv_on;
   logic                      dev_on;
   logic signed [SPEED_W-1:0] rsp_in;

   assign adv       = !rsp_vld_ff || rsp.ready;
   assign req.ready = adv;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= '0;
      end else if (csr.valid) begin
         min_ff <= csr.minimum_speed;
      end
   end

   assign dk     = {req.curv_ahead[15], req.curv_ahead} - {req.curv_now[15], req.curv_now};
   assign yk     = {req.lat_offset[15], req.lat_offset};
   assign dk_abs = dk[16] ? 16'(-dk) : dk[15:0];
   assign yk_abs = yk[16] ? 16'(-yk) : yk[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= CURV_LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req.valid;
         for (int i = 1; i <= CURV_LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         req_ff <= req.requested_speed;
         d_ff   <= dk_abs;
         a_ff   <= yk_abs;
      end
   end

   spl_curv_ceiling u_curv (
      .clock (clock),
      .en    (adv),
      .d_i   (d_ff),
      .lim_o (lim1)
   );

   spl_dev_ceiling u_dev (
      .clock (clock),
      .en    (adv),
      .a_i   (a_ff),
      .lim_o (lim2_raw)
   );

   spl_delay #(
      .WIDTH (SPEED_W),
      .DEPTH (DEV_PAD)
   ) u_dev_pad (
      .clock (clock),
      .en    (adv),
      .d_i   (lim2_raw),
      .q_o   (lim2)
   );

   spl_delay #(
      .WIDTH (SPEED_W + 2),
      .DEPTH (CURV_LAT)
   ) u_side (
      .clock (clock),
      .en    (adv),
      .d_i   ({req_ff, d_ff != '0, a_ff != '0}),
      .q_o   (side)
   );

   assign req_d   = side[SPEED_W+1:2];
   assign curv_on = side[1];
   assign dev_on  = side[0];

   always_comb begin
      rsp_in = req_d;
      if (curv_on && $signed({3'b000, lim1}) < rsp_in) begin
         rsp_in = $signed({3'b000, lim1});
      end
      if (dev_on && lim2 < rsp_in) begin
         rsp_in = lim2;
      end
      if (rsp_in < min_ff) begin
         rsp_in = min_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= vld_ff[CURV_LAT];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid         = rsp_vld_ff;
   assign rsp.limited_speed = rsp_ff;

endmodule

// ===== design/spl_checker.sv =====
// ----------------------------------------------------------------------------
// Speed limiter port checker
// Watches the ports of the speed limiter for ordering and range errors.
// ----------------------------------------------------------------------------
`include "path_following_speed_limiter_assert.svh"

module spl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] limited_speed,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [15:0] minimum_speed
);

   logic signed [15:0] min_ff;
   logic [7:0]         cnt_ff;
   logic [7:0]         cnt_in;

   always_comb begin
      cnt_in = cnt_ff;
      if (req_valid && req_ready) begin
         cnt_in = 8'(cnt_in + 8'd1);
      end
      if (rsp_valid && rsp_ready) begin
         cnt_in = 8'(cnt_in - 8'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (csr_valid && csr_ready) begin
            min_ff <= $signed(minimum_speed);
         end
      end
   end

   `SPL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(limited_speed), "Stalled response changed.")
   `SPL_ASSERT_NOW(a_floor, rsp_valid, $signed(limited_speed) >= min_ff,
      "Result is below the minimum speed.")
   `SPL_ASSERT_NOW(a_no_extra, rsp_valid, cnt_ff != 8'd0,
      "Response without an outstanding request transfer.")
   `SPL_ASSERT_NOW(a_ready_idle, !rsp_valid, req_ready,
      "Request channel stalled while the output is empty.")

endmodule

bind path_following_speed_limiter spl_checker u_spl_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .limited_speed (rsp.limited_speed),
   .csr_valid     (csr.valid),
   .csr_ready     (csr.ready),
   .minimum_speed (csr.minimum_speed)
);
